### design/escc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escc_pkg
// Shared types and constants of the event sequence continuity checker.
// ----------------------------------------------------------------------------
package escc_pkg;

    localparam int SOURCES_DEFAULT = 16;

    localparam int FIELD_W = 32;
    localparam int CMD_W   = 3;

    // Command codes of an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_EVENTS    = 3'd0,
        CMD_INFO_HDR  = 3'd1,
        CMD_INFO_ID   = 3'd2,
        CMD_TEXT      = 3'd3,
        CMD_END_DATA  = 3'd4,
        CMD_NEW_FILE  = 3'd5
    } cmd_t;

    // Bits of the once-per-file report mask.
    localparam int REP_NO_INFO   = 0;
    localparam int REP_NO_TEXT   = 1;
    localparam int REP_AFTER_END = 2;
    localparam int REP_W         = 3;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture the input item and restart the table scan
        logic scan;     // step the table scan
        logic commit;   // update state and load the result register
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_end; // lookup finished (hit, end of table, or no lookup needed)
    } dp_status_t;

endpackage

### design/escc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escc_ctrl
// Sequencer: accepts an item, runs the table scan, commits the result into
// the output register once that register is free.
// ----------------------------------------------------------------------------
module escc_ctrl
    import escc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_end) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### design/escc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escc_dp
// Datapath: input item registers, source table memory with its scan pointer,
// file status, saturating event total and the result register.
// ----------------------------------------------------------------------------
module escc_dp
    import escc_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [FIELD_W-1:0] s_source_id,
    input  logic [FIELD_W-1:0] s_start_event,
    input  logic [FIELD_W-1:0] s_event_count,
    output logic               m_no_info_seen,
    output logic               m_no_text_seen,
    output logic               m_event_after_end,
    output logic               m_sequence_jump,
    output logic [FIELD_W-1:0] m_jump_from,
    output logic               m_source_unknown,
    output logic               m_table_full,
    output logic               m_events_before_info,
    output logic               m_duplicate_info,
    output logic               m_no_events_before_end,
    output logic               m_duplicate_end
);

    localparam int CW = $clog2(SOURCES + 1);
    localparam int IW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(SOURCES);

    // Table word: source id in the upper half, last event number below.
    logic [2*FIELD_W-1:0] tbl_mem [SOURCES];
    logic [2*FIELD_W-1:0] rd_data_reg;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [FIELD_W-1:0]   wr_last;

    logic [CMD_W-1:0]   cmd_reg;
    logic [FIELD_W-1:0] src_reg, first_reg, cnt_reg;

    logic [CW-1:0]      count_reg, count_next;
    logic [FIELD_W-1:0] total_reg, total_next;
    logic               info_reg, info_next;
    logic               text_reg, text_next;
    logic               end_reg, end_next;
    logic [REP_W-1:0]   rep_reg, rep_next;

    logic [CW-1:0]      idx_reg;
    logic               chk_valid_reg;
    logic [IW-1:0]      chk_idx_reg;
    logic               hit_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic [FIELD_W-1:0] hit_last_reg;

    logic               is_events;
    logic               match;
    logic               idx_in_range;
    logic               tbl_full;
    logic [FIELD_W-1:0] end_evt_num;
    logic [FIELD_W:0]   total_sum;

    logic               r_no_info, r_no_text, r_after_end, r_jump, r_unknown, r_full;
    logic               r_before_info, r_dup_info, r_no_events, r_dup_end;
    logic [FIELD_W-1:0] r_jump_from;

    assign is_events    = (cmd_reg == CMD_EVENTS);
    assign idx_in_range = (idx_reg < count_reg);
    assign match        = chk_valid_reg && (rd_data_reg[2*FIELD_W-1:FIELD_W] == src_reg);
    assign tbl_full     = (count_reg == CNT_MAX);
    assign end_evt_num  = first_reg + cnt_reg - 32'd1;
    assign total_sum    = {1'b0, total_reg} + {1'b0, cnt_reg};

    // The scan ends on the first match, so the lowest matching entry wins.
    assign status.scan_end = !is_events || match || (!idx_in_range && !chk_valid_reg);

    always_comb begin
        count_next    = count_reg;
        total_next    = total_reg;
        info_next     = info_reg;
        text_next     = text_reg;
        end_next      = end_reg;
        rep_next      = rep_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IW-1:0];
        wr_last       = '0;
        r_no_info     = 1'b0;
        r_no_text     = 1'b0;
        r_after_end   = 1'b0;
        r_jump        = 1'b0;
        r_jump_from   = '0;
        r_unknown     = 1'b0;
        r_full        = 1'b0;
        r_before_info = 1'b0;
        r_dup_info    = 1'b0;
        r_no_events   = 1'b0;
        r_dup_end     = 1'b0;
        case (cmd_reg)
            CMD_EVENTS: begin
                r_no_info   = !info_reg && !rep_reg[REP_NO_INFO];
                r_no_text   = !text_reg && !rep_reg[REP_NO_TEXT];
                r_after_end = end_reg && !rep_reg[REP_AFTER_END];
                rep_next    = rep_reg | {r_after_end, r_no_text, r_no_info};
                total_next  = total_sum[FIELD_W] ? '1 : total_sum[FIELD_W-1:0];
                wr_last     = end_evt_num;
                if (hit_reg) begin
                    r_jump      = (hit_last_reg + 32'd1) != first_reg;
                    r_jump_from = r_jump ? hit_last_reg : '0;
                    wr_en       = 1'b1;
                    wr_addr     = hit_idx_reg;
                end else begin
                    r_unknown = 1'b1;
                    if (tbl_full) begin
                        r_full = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            CMD_INFO_HDR: begin
                r_before_info = (total_reg != '0);
                r_dup_info    = info_reg;
                info_next     = 1'b1;
                count_next    = '0;
            end
            CMD_INFO_ID: begin
                if (tbl_full) begin
                    r_full = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_TEXT: begin
                text_next = 1'b1;
            end
            CMD_END_DATA: begin
                r_no_events = (total_reg == '0);
                r_dup_end   = end_reg;
                end_next    = 1'b1;
            end
            CMD_NEW_FILE: begin
                count_next = '0;
                info_next  = 1'b0;
                text_next  = 1'b0;
                end_next   = 1'b0;
                rep_next   = '0;
            end
            default: begin
            end
        endcase
    end

    // Table memory: one write port used at commit, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            tbl_mem[wr_addr] <= {src_reg, wr_last};
        end
        rd_data_reg <= tbl_mem[idx_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            total_reg     <= '0;
            info_reg      <= 1'b0;
            text_reg      <= 1'b0;
            end_reg       <= 1'b0;
            rep_reg       <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg       <= '0;
                chk_valid_reg <= 1'b0;
                hit_reg       <= 1'b0;
            end else if (cmd.scan) begin
                chk_valid_reg <= idx_in_range && !match;
                if (idx_in_range) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (match && is_events) begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                count_reg <= count_next;
                total_reg <= total_next;
                info_reg  <= info_next;
                text_reg  <= text_next;
                end_reg   <= end_next;
                rep_reg   <= rep_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= s_cmd;
            src_reg   <= s_source_id;
            first_reg <= s_start_event;
            cnt_reg   <= s_event_count;
        end
        if (cmd.scan) begin
            chk_idx_reg <= idx_reg[IW-1:0];
            if (match) begin
                hit_idx_reg  <= chk_idx_reg;
                hit_last_reg <= rd_data_reg[FIELD_W-1:0];
            end
        end
        if (cmd.commit) begin
            m_no_info_seen         <= r_no_info;
            m_no_text_seen         <= r_no_text;
            m_event_after_end      <= r_after_end;
            m_sequence_jump        <= r_jump;
            m_jump_from            <= r_jump_from;
            m_source_unknown       <= r_unknown;
            m_table_full           <= r_full;
            m_events_before_info   <= r_before_info;
            m_duplicate_info       <= r_dup_info;
            m_no_events_before_end <= r_no_events;
            m_duplicate_end        <= r_dup_end;
        end
    end

endmodule

### design/event_sequence_continuity_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_sequence_continuity_checker_core
// Checks a stream of acquisition cluster descriptors against a table of
// source ids and their last event numbers, and flags file-level errors.
// ----------------------------------------------------------------------------
//  Channel   Prefix  Direction  Contents
//  input     s_      in         cmd, source_id, start_event, event_count
//  result    m_      out        one flag record per input item
//
//  Each item passes through the states IDLE, SCAN and COMMIT before the input is
//  ready again. Non-events items and events items with an empty table need no
//  table lookup; otherwise an events item scans the table until a hit or its last
//  entry, at most SOURCES entries, one entry per cycle through the read port.
//  Reset (aresetn low, synchronous) empties the table and clears all file status.
//  A result waiting in the output register stalls only the commit of the next item.
// ----------------------------------------------------------------------------
module event_sequence_continuity_checker_core
    import escc_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [FIELD_W-1:0] s_source_id,
    input  logic [FIELD_W-1:0] s_start_event,
    input  logic [FIELD_W-1:0] s_event_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_no_info_seen,
    output logic               m_no_text_seen,
    output logic               m_event_after_end,
    output logic               m_sequence_jump,
    output logic [FIELD_W-1:0] m_jump_from,
    output logic               m_source_unknown,
    output logic               m_table_full,
    output logic               m_events_before_info,
    output logic               m_duplicate_info,
    output logic               m_no_events_before_end,
    output logic               m_duplicate_end
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    escc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    escc_dp #(
        .SOURCES (SOURCES)
    ) u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .status                 (status),
        .s_cmd                  (s_cmd),
        .s_source_id            (s_source_id),
        .s_start_event          (s_start_event),
        .s_event_count          (s_event_count),
        .m_no_info_seen         (m_no_info_seen),
        .m_no_text_seen         (m_no_text_seen),
        .m_event_after_end      (m_event_after_end),
        .m_sequence_jump        (m_sequence_jump),
        .m_jump_from            (m_jump_from),
        .m_source_unknown       (m_source_unknown),
        .m_table_full           (m_table_full),
        .m_events_before_info   (m_events_before_info),
        .m_duplicate_info       (m_duplicate_info),
        .m_no_events_before_end (m_no_events_before_end),
        .m_duplicate_end        (m_duplicate_end)
    );

endmodule
